// ===== src/pcht_pkg.sv =====
package pcht_pkg;

	localparam int SLOTS = 4096;
	localparam int SLOT_BITS = $clog2(SLOTS);
	localparam int NODE_BITS = 20;
	localparam int COUNT_BITS = 32;
	localparam int IDX_BITS = 12;
	localparam int NC_BITS = 21;
	localparam int ADDR_BITS = 3;
	localparam int DATA_BITS = 32;

	localparam logic [NC_BITS-1:0] NC_RESET = NC_BITS'(1048576);

	// register index, taken from paddr above the byte offset
	localparam logic REG_NODE_COUNT = 1'b0;

	typedef enum logic {
		CMD_RECORD = 1'b0,
		CMD_READ   = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_FULL      = 2'd1,
		STAT_UNWRITTEN = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_HASH,
		S_SLOT,
		S_ENTRY,
		S_READ
	} state_t;

	typedef struct packed {
		cmd_t                 cmd;
		logic [NODE_BITS-1:0] node;
		logic [NODE_BITS-1:0] context_req;
		logic [IDX_BITS-1:0]  entry_index;
	} req_t;

	typedef struct packed {
		logic [IDX_BITS-1:0]   result_index;
		logic                  was_present;
		logic [NODE_BITS-1:0]  source_node;
		logic [NODE_BITS-1:0]  context_node;
		logic [COUNT_BITS-1:0] pair_count;
		status_t               status;
	} result_t;

	typedef struct packed {
		logic                 valid;
		logic [SLOT_BITS-1:0] idx;
	} slot_t;

	typedef struct packed {
		logic [NODE_BITS-1:0]  src;
		logic [NODE_BITS-1:0]  ctx;
		logic [COUNT_BITS-1:0] cnt;
	} entry_t;

	typedef struct packed {
		logic                 slot_we;
		logic                 slot_re;
		logic [SLOT_BITS-1:0] slot_addr;
		slot_t                slot_wdata;
		logic                 ent_we;
		logic                 cnt_we;
		logic [SLOT_BITS-1:0] ent_waddr;
		entry_t               ent_wdata;
		logic                 ent_re;
		logic [SLOT_BITS-1:0] ent_raddr;
	} store_ctl_t;

endpackage

// ===== src/pcht_cfg.sv =====
module pcht_cfg (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [pcht_pkg::ADDR_BITS-1:0]       paddr,
	input  logic [pcht_pkg::DATA_BITS-1:0]       pwdata,
	output logic [pcht_pkg::DATA_BITS-1:0]       prdata,
	output logic                                 pready,
	output logic [pcht_pkg::NC_BITS-1:0]         node_count
);

	logic                          reg_idx;
	logic [pcht_pkg::NC_BITS-1:0]  nc_q;

	assign reg_idx = paddr[pcht_pkg::ADDR_BITS-1];
	assign pready = 1'b1;
	assign node_count = nc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nc_q <= pcht_pkg::NC_RESET;
		end else if (psel && penable && pwrite && (reg_idx == pcht_pkg::REG_NODE_COUNT)) begin
			nc_q <= pwdata[pcht_pkg::NC_BITS-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (reg_idx == pcht_pkg::REG_NODE_COUNT) begin
			prdata = pcht_pkg::DATA_BITS'(nc_q);
		end
	end

endmodule

// ===== src/pcht_hash.sv =====
module pcht_hash (
	input  logic                             clk,
	input  logic [pcht_pkg::NODE_BITS-1:0]   node,
	input  logic [pcht_pkg::NODE_BITS-1:0]   context_req,
	input  logic [pcht_pkg::NC_BITS-1:0]     node_count,
	output logic [pcht_pkg::SLOT_BITS-1:0]   hash_s1
);

	localparam int PROD_BITS = pcht_pkg::NODE_BITS + pcht_pkg::NC_BITS;

	logic [PROD_BITS-1:0] prod;
	logic [PROD_BITS-1:0] sum;

	// slot count is a power of two, so the modulo keeps the low bits
	assign prod = PROD_BITS'(node) * PROD_BITS'(node_count);
	assign sum = prod + PROD_BITS'(context_req);

	always_ff @(posedge clk) begin
		hash_s1 <= sum[pcht_pkg::SLOT_BITS-1:0];
	end

endmodule

// ===== src/pcht_store.sv =====
module pcht_store (
	input  logic                  clk,
	input  pcht_pkg::store_ctl_t  ctl,
	output pcht_pkg::slot_t       slot_rd,
	output pcht_pkg::entry_t      ent_rd
);

	pcht_pkg::slot_t                       slot_mem [pcht_pkg::SLOTS];
	logic [pcht_pkg::NODE_BITS-1:0]        src_mem  [pcht_pkg::SLOTS];
	logic [pcht_pkg::NODE_BITS-1:0]        ctx_mem  [pcht_pkg::SLOTS];
	logic [pcht_pkg::COUNT_BITS-1:0]       cnt_mem  [pcht_pkg::SLOTS];

	// slot table, single port
	always_ff @(posedge clk) begin
		if (ctl.slot_we) begin
			slot_mem[ctl.slot_addr] <= ctl.slot_wdata;
		end
		if (ctl.slot_re) begin
			slot_rd <= slot_mem[ctl.slot_addr];
		end
	end

	// entry list, one write and one read port
	always_ff @(posedge clk) begin
		if (ctl.ent_we) begin
			src_mem[ctl.ent_waddr] <= ctl.ent_wdata.src;
			ctx_mem[ctl.ent_waddr] <= ctl.ent_wdata.ctx;
		end
		if (ctl.ent_we || ctl.cnt_we) begin
			cnt_mem[ctl.ent_waddr] <= ctl.ent_wdata.cnt;
		end
		if (ctl.ent_re) begin
			ent_rd.src <= src_mem[ctl.ent_raddr];
			ent_rd.ctx <= ctx_mem[ctl.ent_raddr];
			ent_rd.cnt <= cnt_mem[ctl.ent_raddr];
		end
	end

endmodule

// ===== src/pair_count_hash_table.sv =====
// Pair occurrence counter. A record request (cmd 0) hashes (node, context_req) as
// node * node_count + context_req modulo 4096 and probes the slot table linearly; a new
// pair is appended to the entry list with count 1, a known pair has its count incremented
// (saturating). A read request (cmd 1) returns entry entry_index. After reset busy stays
// high for a clearing pass over the slot table. A read issues the entry read when it is
// accepted and then loads the result. A record registers the hash, then probes until it
// reaches an empty slot or a matching entry; each probe is one slot table read followed,
// if the slot is occupied, by one entry read. A record of an absent pair into a full
// table walks all 4096 slots and reports status 1. Each result appears on result in
// exactly the one cycle that done is high and is held there until the next result; the
// receiver cannot stall it, and a new request may be started in that same cycle.
module pair_count_hash_table (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  pcht_pkg::req_t                       req,
	output logic                                 done,
	output pcht_pkg::result_t                    result,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [pcht_pkg::ADDR_BITS-1:0]       paddr,
	input  logic [pcht_pkg::DATA_BITS-1:0]       pwdata,
	output logic [pcht_pkg::DATA_BITS-1:0]       prdata,
	output logic                                 pready
);

	localparam int USED_BITS = pcht_pkg::SLOT_BITS + 1;

	pcht_pkg::state_t                     state_q, state_d;
	pcht_pkg::req_t                       req_q;
	pcht_pkg::result_t                    result_q, res_d;
	pcht_pkg::store_ctl_t                 ctl;
	pcht_pkg::slot_t                      slot_rd;
	pcht_pkg::entry_t                     ent_rd;
	logic [pcht_pkg::NC_BITS-1:0]         node_count;
	logic [pcht_pkg::SLOT_BITS-1:0]       hash_s1;
	logic [pcht_pkg::SLOT_BITS-1:0]       clr_q;
	logic [pcht_pkg::SLOT_BITS-1:0]       probe_q;
	logic [pcht_pkg::SLOT_BITS-1:0]       probes_q;
	logic [USED_BITS-1:0]                 used_q;
	logic                                 done_q;
	logic                                 res_load;
	logic                                 accept;
	logic                                 table_full;
	logic                                 pair_match;
	logic                                 last_probe;
	logic                                 rd_ok;
	logic [pcht_pkg::COUNT_BITS-1:0]      cnt_inc;

	pcht_cfg u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.node_count (node_count)
	);

	pcht_hash u_hash (
		.clk         (clk),
		.node        (req.node),
		.context_req (req.context_req),
		.node_count  (node_count),
		.hash_s1     (hash_s1)
	);

	pcht_store u_store (
		.clk     (clk),
		.ctl     (ctl),
		.slot_rd (slot_rd),
		.ent_rd  (ent_rd)
	);

	assign busy = (state_q != pcht_pkg::S_IDLE);
	assign accept = start && !busy;
	assign done = done_q;
	assign result = result_q;

	assign table_full = (used_q == USED_BITS'(pcht_pkg::SLOTS));
	assign pair_match = (ent_rd.src == req_q.node) && (ent_rd.ctx == req_q.context_req);
	assign last_probe = (probes_q == '1);
	assign rd_ok = (32'(req_q.entry_index) < 32'(used_q))
		&& (32'(req_q.entry_index) < 32'(pcht_pkg::SLOTS));
	assign cnt_inc = (ent_rd.cnt == '1) ? ent_rd.cnt : ent_rd.cnt + 1'b1;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			pcht_pkg::S_CLEAR: begin
				if (clr_q == '1) begin
					state_d = pcht_pkg::S_IDLE;
				end
			end
			pcht_pkg::S_IDLE: begin
				if (accept) begin
					state_d = (req.cmd == pcht_pkg::CMD_READ) ? pcht_pkg::S_READ
						: pcht_pkg::S_HASH;
				end
			end
			pcht_pkg::S_HASH: begin
				state_d = pcht_pkg::S_SLOT;
			end
			pcht_pkg::S_SLOT: begin
				state_d = slot_rd.valid ? pcht_pkg::S_ENTRY : pcht_pkg::S_IDLE;
			end
			pcht_pkg::S_ENTRY: begin
				state_d = (pair_match || last_probe) ? pcht_pkg::S_IDLE : pcht_pkg::S_SLOT;
			end
			pcht_pkg::S_READ: begin
				state_d = pcht_pkg::S_IDLE;
			end
			default: begin
				state_d = pcht_pkg::S_IDLE;
			end
		endcase
	end

	// outputs: memory controls and the result
	always_comb begin
		ctl = '0;
		res_d = '0;
		res_load = 1'b0;
		case (state_q)
			pcht_pkg::S_CLEAR: begin
				ctl.slot_we = 1'b1;
				ctl.slot_addr = clr_q;
			end
			pcht_pkg::S_IDLE: begin
				ctl.ent_re = accept;
				ctl.ent_raddr = pcht_pkg::SLOT_BITS'(req.entry_index);
			end
			pcht_pkg::S_HASH: begin
				ctl.slot_re = 1'b1;
				ctl.slot_addr = hash_s1;
			end
			pcht_pkg::S_SLOT: begin
				if (slot_rd.valid) begin
					ctl.ent_re = 1'b1;
					ctl.ent_raddr = slot_rd.idx;
				end else begin
					res_load = 1'b1;
					res_d.source_node = req_q.node;
					res_d.context_node = req_q.context_req;
					if (table_full) begin
						res_d.status = pcht_pkg::STAT_FULL;
					end else begin
						ctl.slot_we = 1'b1;
						ctl.slot_addr = probe_q;
						ctl.slot_wdata.valid = 1'b1;
						ctl.slot_wdata.idx = used_q[pcht_pkg::SLOT_BITS-1:0];
						ctl.ent_we = 1'b1;
						ctl.ent_waddr = used_q[pcht_pkg::SLOT_BITS-1:0];
						ctl.ent_wdata.src = req_q.node;
						ctl.ent_wdata.ctx = req_q.context_req;
						ctl.ent_wdata.cnt = pcht_pkg::COUNT_BITS'(1);
						res_d.result_index = pcht_pkg::IDX_BITS'(used_q);
						res_d.pair_count = pcht_pkg::COUNT_BITS'(1);
						res_d.status = pcht_pkg::STAT_OK;
					end
				end
			end
			pcht_pkg::S_ENTRY: begin
				if (pair_match) begin
					ctl.cnt_we = 1'b1;
					ctl.ent_waddr = slot_rd.idx;
					ctl.ent_wdata.cnt = cnt_inc;
					res_load = 1'b1;
					res_d.result_index = pcht_pkg::IDX_BITS'(slot_rd.idx);
					res_d.was_present = 1'b1;
					res_d.source_node = req_q.node;
					res_d.context_node = req_q.context_req;
					res_d.pair_count = cnt_inc;
					res_d.status = pcht_pkg::STAT_OK;
				end else if (last_probe) begin
					res_load = 1'b1;
					res_d.source_node = req_q.node;
					res_d.context_node = req_q.context_req;
					res_d.status = pcht_pkg::STAT_FULL;
				end else begin
					ctl.slot_re = 1'b1;
					ctl.slot_addr = probe_q + 1'b1;
				end
			end
			pcht_pkg::S_READ: begin
				res_load = 1'b1;
				res_d.result_index = req_q.entry_index;
				if (rd_ok) begin
					res_d.source_node = ent_rd.src;
					res_d.context_node = ent_rd.ctx;
					res_d.pair_count = ent_rd.cnt;
					res_d.status = pcht_pkg::STAT_OK;
				end else begin
					res_d.status = pcht_pkg::STAT_UNWRITTEN;
				end
			end
			default: begin
				res_load = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pcht_pkg::S_CLEAR;
			clr_q <= '0;
			used_q <= '0;
			done_q <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q <= res_load;
			if (state_q == pcht_pkg::S_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (ctl.ent_we) begin
				used_q <= used_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req;
		end
		if (res_load) begin
			result_q <= res_d;
		end
		if (state_q == pcht_pkg::S_HASH) begin
			probe_q <= hash_s1;
			probes_q <= '0;
		end else if (ctl.slot_re) begin
			probe_q <= probe_q + 1'b1;
			probes_q <= probes_q + 1'b1;
		end
	end

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("request accepted but block not busy");

	a_done_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !$past(done) || $past(accept, 2) || $past(busy))
		else $error("result strobe without work");

	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= USED_BITS'(pcht_pkg::SLOTS))
		else $error("entry count beyond slot count");

	a_full_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		done && (result.status == pcht_pkg::STAT_FULL) |-> table_full)
		else $error("table full reported with free entries");

	a_present_ok: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.was_present |-> result.status == pcht_pkg::STAT_OK)
		else $error("known pair reported with error status");

endmodule
